@@ rtl/core/psca_pkg.sv @@
// ----------------------------------------------------------------------------
// Per-source connection admission package
// Sizes, operation codes and status codes shared by the admission block.
// ----------------------------------------------------------------------------
package psca_pkg;

  localparam int MAX_SOURCES = 16;
  localparam int MAX_SLOTS   = 8;
  localparam int SRC_W       = $clog2(MAX_SOURCES);
  localparam int SLOT_W      = $clog2(MAX_SLOTS);
  localparam int SLOT_CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int TOTAL_W     = $clog2(MAX_SOURCES + 1);
  localparam int ADDR_W      = SRC_W + SLOT_W;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_ADMIT   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_LOOKUP  = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_UNKNOWN    = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_DUP        = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;
  localparam logic [2:0] ST_BAD_LIMIT  = 3'd5;
  localparam logic [2:0] ST_ID_MISSING = 3'd6;

endpackage

@@ rtl/core/per_source_connection_admission.sv @@
// ----------------------------------------------------------------------------
// Per-source connection admission table
// A command is taken when start is high and busy is low; its fields are
// operation, source_ip, limit and conn_id. Exactly one result follows, shown
// for one cycle with done high: status, assigned_id, slot_index, found_ip and
// sources_in_use. The receiver cannot stall, so a result must be taken in
// the cycle that done is high.
// Source addresses sit in a 16-entry memory and slot ids in a 128-entry
// memory, both with registered reads, so every entry visited takes a read
// state and a compare state. Add also checks the limit and clears the
// slot ids of the new source, and lookup reads the address after the
// match; a command rejected at once shows its result in the cycle after
// acceptance and never raises busy. Busy is high from acceptance and is
// low again in the cycle in which done is high. Reset returns the table
// to empty and the id counter to one; no clearing pass is needed, since the
// slot ids of a source are cleared when it is added.
// ----------------------------------------------------------------------------
module per_source_connection_admission
  import psca_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [31:0] source_ip,
  input  logic [3:0]  limit,
  input  logic [31:0] conn_id,
  output logic        done,
  output logic [2:0]  status,
  output logic [31:0] assigned_id,
  output logic [2:0]  slot_index,
  output logic [31:0] found_ip,
  output logic [4:0]  sources_in_use
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SRC_RD  = 4'd1;
  localparam logic [3:0] S_SRC_CMP = 4'd2;
  localparam logic [3:0] S_ADD_CHK = 4'd3;
  localparam logic [3:0] S_CLEAR   = 4'd4;
  localparam logic [3:0] S_ADMIT   = 4'd5;
  localparam logic [3:0] S_ID_RD   = 4'd6;
  localparam logic [3:0] S_ID_CMP  = 4'd7;
  localparam logic [3:0] S_LOOK    = 4'd8;

  logic [3:0]            state;
  logic [1:0]            op;
  logic [31:0]           ip;
  logic [3:0]            lim;
  logic [31:0]           id;
  logic [SRC_W-1:0]      idx;
  logic [SLOT_CNT_W-1:0] sj;
  logic [TOTAL_W-1:0]    total;
  logic [31:0]           next_id;

  logic [31:0]          addr_mem [MAX_SOURCES];
  logic [31:0]          addr_rdata;
  logic [31:0]          id_mem [MAX_SOURCES*MAX_SLOTS];
  logic [31:0]          id_rdata;
  logic [3:0]           lim_tab [MAX_SOURCES];
  logic [MAX_SLOTS-1:0] alive [MAX_SOURCES];

  logic                 addr_we;
  logic                 addr_re;
  logic                 id_we;
  logic                 id_re;
  logic [SRC_W-1:0]     addr_waddr;
  logic [ADDR_W-1:0]    id_addr;
  logic [31:0]          id_wdata;
  logic [SRC_W-1:0]     total_idx;
  logic                 last_src;
  logic                 have_free;
  logic [SLOT_W-1:0]    free_slot;

  assign total_idx = total[SRC_W-1:0];
  assign last_src  = ({1'b0, idx} == total - TOTAL_W'(1));
  assign busy      = (state != S_IDLE);

  always_comb begin
    have_free = 1'b0;
    free_slot = '0;
    for (int k = 0; k < MAX_SLOTS; k++) begin
      if ((SLOT_CNT_W'(k) < lim_tab[idx][SLOT_CNT_W-1:0]) && !alive[idx][k]) begin
        have_free = 1'b1;
        free_slot = SLOT_W'(k);
      end
    end
  end

  always_comb begin
    addr_we    = (state == S_ADD_CHK) && (lim <= 4'(MAX_SLOTS));
    addr_re    = (state == S_SRC_RD);
    addr_waddr = total_idx;
    id_we      = 1'b0;
    id_re      = 1'b0;
    id_wdata   = '0;
    id_addr    = {idx, sj[SLOT_W-1:0]};
    unique case (state)
      S_CLEAR: begin
        id_we   = 1'b1;
        id_addr = {total_idx, sj[SLOT_W-1:0]};
      end
      S_ADMIT: begin
        id_we    = have_free;
        id_wdata = next_id;
        id_addr  = {idx, free_slot};
      end
      S_ID_RD: begin
        id_re = (sj < lim_tab[idx][SLOT_CNT_W-1:0]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (addr_we) begin
      addr_mem[addr_waddr] <= ip;
    end
    if (addr_re) begin
      addr_rdata <= addr_mem[idx];
    end
    if (state == S_ID_CMP) begin
      addr_rdata <= addr_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (id_we) begin
      id_mem[id_addr] <= id_wdata;
    end
    if (id_re) begin
      id_rdata <= id_mem[id_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      total   <= '0;
      next_id <= 32'd1;
      for (int s = 0; s < MAX_SOURCES; s++) begin
        alive[s] <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op             <= operation;
            ip             <= source_ip;
            lim            <= limit;
            id             <= conn_id;
            idx            <= '0;
            sj             <= '0;
            status         <= ST_OK;
            assigned_id    <= '0;
            slot_index     <= '0;
            found_ip       <= '0;
            sources_in_use <= total;
            priority if (operation == OP_ADD) begin
              if (total >= TOTAL_W'(MAX_SOURCES)) begin
                status <= ST_TABLE_FULL;
                done   <= 1'b1;
              end else if (total == '0) begin
                state <= S_ADD_CHK;
              end else begin
                state <= S_SRC_RD;
              end
            end else if (operation == OP_ADMIT) begin
              if (total == '0) begin
                status <= ST_UNKNOWN;
                done   <= 1'b1;
              end else begin
                state <= S_SRC_RD;
              end
            end else begin
              if (conn_id == '0 || total == '0) begin
                status <= ST_ID_MISSING;
                done   <= 1'b1;
              end else begin
                state <= S_ID_RD;
              end
            end
          end
        end
        S_SRC_RD: begin
          state <= S_SRC_CMP;
        end
        S_SRC_CMP: begin
          if (addr_rdata == ip) begin
            if (op == OP_ADD) begin
              status <= ST_DUP;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              state <= S_ADMIT;
            end
          end else if (last_src) begin
            if (op == OP_ADD) begin
              state <= S_ADD_CHK;
            end else begin
              status <= ST_UNKNOWN;
              done   <= 1'b1;
              state  <= S_IDLE;
            end
          end else begin
            idx   <= idx + SRC_W'(1);
            state <= S_SRC_RD;
          end
        end
        S_ADD_CHK: begin
          if (lim > 4'(MAX_SLOTS)) begin
            status <= ST_BAD_LIMIT;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            lim_tab[total_idx] <= lim;
            alive[total_idx]   <= '0;
            sj                 <= '0;
            state              <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          if (sj == SLOT_CNT_W'(MAX_SLOTS - 1)) begin
            total          <= total + TOTAL_W'(1);
            sources_in_use <= total + TOTAL_W'(1);
            done           <= 1'b1;
            state          <= S_IDLE;
          end else begin
            sj <= sj + SLOT_CNT_W'(1);
          end
        end
        S_ADMIT: begin
          if (have_free) begin
            alive[idx][free_slot] <= 1'b1;
            assigned_id           <= next_id;
            slot_index            <= 3'(free_slot);
            next_id <= (next_id == '1) ? 32'd1 : next_id + 32'd1;
          end else begin
            status <= ST_FULL;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_ID_RD: begin
          if (id_re) begin
            state <= S_ID_CMP;
          end else if (last_src) begin
            status <= ST_ID_MISSING;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            idx <= idx + SRC_W'(1);
            sj  <= '0;
          end
        end
        S_ID_CMP: begin
          if (id_rdata == id) begin
            if (op == OP_RELEASE) begin
              alive[idx][sj[SLOT_W-1:0]] <= 1'b0;
              slot_index                 <= 3'(sj[SLOT_W-1:0]);
              done                       <= 1'b1;
              state                      <= S_IDLE;
            end else begin
              state <= S_LOOK;
            end
          end else begin
            sj    <= sj + SLOT_CNT_W'(1);
            state <= S_ID_RD;
          end
        end
        S_LOOK: begin
          found_ip <= addr_rdata;
          done     <= 1'b1;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
